// ===== hw/rtl/lsbgf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbgf_pkg
// Shared types and constants of the lidar scan binning and gap fill block.
// ----------------------------------------------------------------------------
package lsbgf_pkg;

  localparam int unsigned BinCount  = 360;
  localparam int unsigned BinW      = 9;
  localparam int unsigned DistW     = 18;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned DistQ2W   = 20;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned AngFrac   = 14;
  localparam int unsigned AngSumW   = 23;
  localparam int unsigned DegScale  = 90;
  localparam int unsigned RoundBias = 8192;
  localparam int unsigned HalfTurn  = 180;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_POINT = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    WSEL_CLEAR,
    WSEL_POINT,
    WSEL_FILL
  } wsel_e;

  typedef enum logic {
    RSEL_IDX,
    RSEL_FILL
  } rsel_e;

  typedef struct packed {
    logic  req_load;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  mem_we;
    wsel_e wsel;
    logic  mem_re;
    rsel_e rsel;
    logic  win_shift;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fill_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/lsbgf_datapath.sv =====
// ----------------------------------------------------------------------------
// lsbgf_datapath
// Bin memory, request registers, sweep counter, fill window and output stage.
// ----------------------------------------------------------------------------
module lsbgf_datapath
  import lsbgf_pkg::*;
#(
  parameter int unsigned FILL_LIMIT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [AngleW-1:0]  angle_q14_i,
  input  logic [DistQ2W-1:0] dist_q2_i,
  input  logic [BinW-1:0]    bin_index_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [BinW-1:0]    bin_number_o,
  output logic [DistW-1:0]   distance_mm_o
);

  localparam int unsigned CntW = $clog2(BinCount + FILL_LIMIT + 1);

  logic [DistW-1:0]   mem_q [BinCount];
  logic [DistW-1:0]   rd_q;
  logic [DistW-1:0]   win_q [FILL_LIMIT];
  logic [AngleW-1:0]  angle_q;
  logic [DistQ2W-1:0] dist_q;
  logic [BinW-1:0]    idx_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [BinW-1:0]    out_bin_q;
  logic [DistW-1:0]   out_dist_q;

  logic [AngSumW-1:0] ang_sum;
  logic [BinW-1:0]    deg;
  logic [BinW:0]      bin_raw;
  logic [BinW-1:0]    point_bin;
  logic [DistW-1:0]   point_dist;
  logic [DistW-1:0]   fill_val;
  logic [BinW-1:0]    fill_waddr;
  logic [BinW-1:0]    fill_raddr;
  logic               idx_ok;
  logic               we;
  logic [BinW-1:0]    waddr;
  logic [DistW-1:0]   wdata;
  logic [BinW-1:0]    raddr;

  // heading to bin
  assign ang_sum    = AngSumW'(angle_q) * AngSumW'(DegScale) + AngSumW'(RoundBias);
  assign deg        = ang_sum[AngSumW-1:AngFrac];
  assign bin_raw    = {1'b0, deg} + (BinW+1)'(HalfTurn);
  assign point_bin  = (bin_raw >= (BinW+1)'(BinCount)) ? BinW'(bin_raw - (BinW+1)'(BinCount))
                                                       : bin_raw[BinW-1:0];
  assign point_dist = dist_q[DistQ2W-1:2];

  // first nonzero entry of the window
  always_comb begin
    fill_val = '0;
    for (int k = FILL_LIMIT - 1; k >= 1; k--) begin
      if (win_q[k] != '0) begin
        fill_val = win_q[k];
      end
    end
    if (win_q[0] != '0) begin
      fill_val = win_q[0];
    end
  end

  assign fill_waddr = BinW'(cnt_q - CntW'(FILL_LIMIT));
  assign fill_raddr = (cnt_q >= CntW'(BinCount)) ? BinW'(cnt_q - CntW'(BinCount))
                                                  : cnt_q[BinW-1:0];
  assign idx_ok     = (idx_q < BinW'(BinCount));

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[BinW-1:0];
    wdata = '0;
    unique case (cmd_i.wsel)
      WSEL_CLEAR: begin
        we    = cmd_i.mem_we;
        waddr = cnt_q[BinW-1:0];
        wdata = '0;
      end
      WSEL_POINT: begin
        we    = cmd_i.mem_we && (point_dist != '0);
        waddr = point_bin;
        wdata = point_dist;
      end
      WSEL_FILL: begin
        we    = cmd_i.mem_we && (cnt_q >= CntW'(FILL_LIMIT));
        waddr = fill_waddr;
        wdata = fill_val;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = (cmd_i.rsel == RSEL_FILL) ? fill_raddr : (idx_ok ? idx_q : '0);

  // bin memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // request and window registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      angle_q <= angle_q14_i;
      dist_q  <= dist_q2_i;
      idx_q   <= bin_index_i;
    end
    if (cmd_i.win_shift) begin
      for (int k = 0; k < FILL_LIMIT - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[FILL_LIMIT-1] <= rd_q;
    end
    if (cmd_i.out_load) begin
      out_bin_q  <= idx_q;
      out_dist_q <= idx_ok ? rd_q : '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.clear_last = (cnt_q == CntW'(BinCount - 1));
  assign sts_o.fill_last  = (cnt_q == CntW'(BinCount + FILL_LIMIT - 1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign bin_number_o  = out_bin_q;
  assign distance_mm_o = out_dist_q;

endmodule

// ===== hw/rtl/lsbgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbgf_ctrl
// Request sequencer: clear sweep, point write, bin read and fill walk.
// ----------------------------------------------------------------------------
module lsbgf_ctrl
  import lsbgf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ReqW-1:0] req_type_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_POINT  = 3'd2;
  localparam logic [2:0] ST_READ_A = 3'd3;
  localparam logic [2:0] ST_READ_B = 3'd4;
  localparam logic [2:0] ST_FILL_A = 3'd5;
  localparam logic [2:0] ST_FILL_B = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.wsel = WSEL_CLEAR;
    cmd_o.rsel = RSEL_IDX;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = WSEL_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          unique case (req_e'(req_type_i))
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_POINT: state_d = ST_POINT;
            REQ_FILL:  state_d = ST_FILL_A;
            REQ_READ:  state_d = ST_READ_A;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_POINT: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WSEL_POINT;
        state_d      = ST_IDLE;
      end
      ST_READ_A: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rsel   = RSEL_IDX;
        state_d      = ST_READ_B;
      end
      ST_READ_B: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FILL_A: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rsel   = RSEL_FILL;
        state_d      = ST_FILL_B;
      end
      ST_FILL_B: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.wsel      = WSEL_FILL;
        cmd_o.win_shift = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = sts_i.fill_last ? ST_IDLE : ST_FILL_A;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/lidar_scan_binning_gap_fill.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_binning_gap_fill
// Top level: 360-bin range table with point binning, clear, read and gap fill.
// ----------------------------------------------------------------------------
// One request is served at a time; all work goes through a bin memory with a
// registered read. After reset the table is zeroed by a sweep over all 360 bins
// during which no request is taken. A read holds back its result while the
// previous result is still held. The finish/fill walk does one memory read and
// one write per bin, plus FILL_LIMIT reads to load its look-ahead window.
module lidar_scan_binning_gap_fill
  import lsbgf_pkg::*;
#(
  parameter int unsigned FILL_LIMIT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [AngleW-1:0]  angle_q14_i,
  input  logic [DistQ2W-1:0] dist_q2_i,
  input  logic [BinW-1:0]    bin_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BinW-1:0]    bin_number_o,
  output logic [DistW-1:0]   distance_mm_o
);

  cmd_t cmd;
  sts_t sts;

  lsbgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsbgf_datapath #(
    .FILL_LIMIT (FILL_LIMIT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .angle_q14_i   (angle_q14_i),
    .dist_q2_i     (dist_q2_i),
    .bin_index_i   (bin_index_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .bin_number_o  (bin_number_o),
    .distance_mm_o (distance_mm_o)
  );

endmodule

// ===== hw/rtl/lsbgf_checker.sv =====
// ----------------------------------------------------------------------------
// lsbgf_checker
// Port-level checks of the lidar scan binning block, bound to the top level.
// ----------------------------------------------------------------------------
module lsbgf_checker
  import lsbgf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [ReqW-1:0]    req_type_i,
  input logic [BinW-1:0]    bin_index_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [BinW-1:0]    bin_number_o,
  input logic [DistW-1:0]   distance_mm_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_number_o)
                                    && $stable(distance_mm_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // read into an empty output slot shows up with the requested bin
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_READ) && !out_valid_o
    |-> ##3 (out_valid_o && (bin_number_o == $past(bin_index_i, 3))))
    else $error("read result late or wrong bin");

  // out of range bins read as empty
  a_range_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bin_number_o >= BinW'(BinCount)) |-> distance_mm_o == '0)
    else $error("nonzero range for out of range bin");

  // no result without a read request in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without request");

endmodule

bind lidar_scan_binning_gap_fill lsbgf_checker u_lsbgf_checker (.*);
